// ----- src/rbsi_pkg.sv -----
// Shared constants for the ray/box slab intersection block.
// Holds default widths and configuration register indexes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rbsi_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIZE_X   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIZE_Y   = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIZE_Z   = 3'd5;
endpackage
`default_nettype wire

// ----- src/ray_box_slab_intersect.sv -----
// Top level of the ray against axis-aligned box slab test.
// Depends on rbsi_pkg, rbsi_slab, rbsi_merge and rbsi_face.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// A request is presented on start_*, dir_*, inv_dir_*, t_lower and t_upper
// and taken at a clock edge where start is high and busy is low. busy is low
// except during reset, so a new request may be issued in every cycle.
// The box is set through the configuration channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data): indexes 0..2 are the center x/y/z, 3..5 the full
// size x/y/z (low COORD_WIDTH-1 bits used); other indexes are ignored.
// cfg_ready is always high. Write configuration only while no request is
// in flight.
// Order: the request passes the per-axis slab products, then the merge of
// the slabs and the window, then hit point, offset and face; the result
// then appears with done high.
// Throughput is one request per cycle; every stage is a register step.
// Results hold for one cycle; the receiver cannot stall the block.
// Reset clears all in-flight requests and sets centers to 0 and sizes to 1.0.
module ray_box_slab_intersect #(
  parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [COORD_WIDTH-1:0]          start_x,
  input  wire logic signed [COORD_WIDTH-1:0]          start_y,
  input  wire logic signed [COORD_WIDTH-1:0]          start_z,
  input  wire logic signed [COORD_WIDTH-1:0]          dir_x,
  input  wire logic signed [COORD_WIDTH-1:0]          dir_y,
  input  wire logic signed [COORD_WIDTH-1:0]          dir_z,
  input  wire logic signed [COORD_WIDTH-1:0]          inv_dir_x,
  input  wire logic signed [COORD_WIDTH-1:0]          inv_dir_y,
  input  wire logic signed [COORD_WIDTH-1:0]          inv_dir_z,
  input  wire logic signed [COORD_WIDTH-1:0]          t_lower,
  input  wire logic signed [COORD_WIDTH-1:0]          t_upper,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [rbsi_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  wire logic [COORD_WIDTH-1:0]                 cfg_data,
  output logic                                        done,
  output logic                                        hit,
  output logic signed [COORD_WIDTH-1:0]               t_hit,
  output logic [2:0]                                  face,
  output logic                                        no_face
);
  import rbsi_pkg::*;

  localparam int W = COORD_WIDTH;

  logic signed [W-1:0] center [3];
  logic [W-2:0] size [3];
  logic accept;
  logic [2:0] sv;
  logic signed [W-1:0] tn [3], tf [3], st_d [3], dr_d [3];
  logic signed [W-1:0] tl_d [4], tu_d [4];
  logic m_valid, m_hit;
  logic signed [W-1:0] m_t;
  logic signed [W-1:0] st_m [2][3], dr_m [2][3];

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Box registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        center[i] <= '0;
        size[i]   <= (W-1)'(1) << FRAC_BITS;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X: center[0] <= cfg_data;
        REG_CENTER_Y: center[1] <= cfg_data;
        REG_CENTER_Z: center[2] <= cfg_data;
        REG_SIZE_X:   size[0]   <= cfg_data[W-2:0];
        REG_SIZE_Y:   size[1]   <= cfg_data[W-2:0];
        REG_SIZE_Z:   size[2]   <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  rbsi_slab #(.W(W), .F(FRAC_BITS)) u_slab_x (
    .clk, .rst, .in_valid(accept), .center(center[0]), .size(size[0]),
    .start(start_x), .dir(dir_x), .inv(inv_dir_x), .out_valid(sv[0]),
    .tn(tn[0]), .tf(tf[0]), .start_o(st_d[0]), .dir_o(dr_d[0]));
  rbsi_slab #(.W(W), .F(FRAC_BITS)) u_slab_y (
    .clk, .rst, .in_valid(accept), .center(center[1]), .size(size[1]),
    .start(start_y), .dir(dir_y), .inv(inv_dir_y), .out_valid(sv[1]),
    .tn(tn[1]), .tf(tf[1]), .start_o(st_d[1]), .dir_o(dr_d[1]));
  rbsi_slab #(.W(W), .F(FRAC_BITS)) u_slab_z (
    .clk, .rst, .in_valid(accept), .center(center[2]), .size(size[2]),
    .start(start_z), .dir(dir_z), .inv(inv_dir_z), .out_valid(sv[2]),
    .tn(tn[2]), .tf(tf[2]), .start_o(st_d[2]), .dir_o(dr_d[2]));

  // Window bounds follow the slab stages; start and dir follow the merge.
  always_ff @(posedge clk) begin
    tl_d[0] <= t_lower;
    tu_d[0] <= t_upper;
    for (int k = 1; k < 4; k++) begin
      tl_d[k] <= tl_d[k-1];
      tu_d[k] <= tu_d[k-1];
    end
    for (int i = 0; i < 3; i++) begin
      st_m[0][i] <= st_d[i];
      dr_m[0][i] <= dr_d[i];
      st_m[1][i] <= st_m[0][i];
      dr_m[1][i] <= dr_m[0][i];
    end
  end

  rbsi_merge #(.W(W)) u_merge (
    .clk, .rst, .in_valid(sv[0] & sv[1] & sv[2]),
    .xn(tn[0]), .xf(tf[0]), .yn(tn[1]), .yf(tf[1]), .zn(tn[2]), .zf(tf[2]),
    .t_lower(tl_d[3]), .t_upper(tu_d[3]),
    .out_valid(m_valid), .hit(m_hit), .t(m_t));

  rbsi_face #(.W(W), .F(FRAC_BITS)) u_face (
    .clk, .rst, .in_valid(m_valid), .hit_in(m_hit), .t_in(m_t),
    .st(st_m[1]), .dr(dr_m[1]), .cen(center),
    .done, .hit, .t_hit, .face, .no_face);
endmodule
`default_nettype wire

// ----- src/rbsi_slab.sv -----
// One axis of the slab test: bounds, differences, products, scaling (4 stages).
// Depends on rbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbsi_slab #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic signed [W-1:0] center,
  input  wire logic        [W-2:0] size,
  input  wire logic signed [W-1:0] start,
  input  wire logic signed [W-1:0] dir,
  input  wire logic signed [W-1:0] inv,
  output logic                     out_valid,
  output logic signed [W-1:0]      tn,
  output logic signed [W-1:0]      tf,
  output logic signed [W-1:0]      start_o,
  output logic signed [W-1:0]      dir_o
);
  import rbsi_pkg::*;

  // Saturate a one-bit-wider sum to W bits.
  function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] v);
    if (v[W] != v[W-1]) sat_sum = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else sat_sum = v[W-1:0];
  endfunction

  // Scale a full product down by F bits, rounding toward minus infinity, and saturate.
  function automatic logic signed [W-1:0] sat_prod(input logic signed [2*W-1:0] p);
    logic signed [2*W-1:0] s;
    s = p >>> F;
    if (s[2*W-1:W-1] != {(W+1){1'b0}} && s[2*W-1:W-1] != {(W+1){1'b1}})
      sat_prod = s[2*W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else sat_prod = s[W-1:0];
  endfunction

  logic signed [W-1:0] half;
  logic signed [W-1:0] lo_b, hi_b;
  logic [3:0] v;
  logic signed [W-1:0] s1_bn, s1_bf, s1_st, s1_dr, s1_inv;
  logic signed [W-1:0] s2_dn, s2_df, s2_st, s2_dr, s2_inv;
  logic signed [2*W-1:0] s3_pn, s3_pf;
  logic signed [W-1:0] s3_st, s3_dr;

  // Box bounds on this axis.
  always_comb begin
    half = signed'({2'b00, size[W-2:1]});
    lo_b = sat_sum({center[W-1], center} - {half[W-1], half});
    hi_b = sat_sum({center[W-1], center} + {half[W-1], half});
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else v <= {v[2:0], in_valid};
  end

  // Stage pipeline for the payload.
  always_ff @(posedge clk) begin
    s1_bn  <= inv[W-1] ? hi_b : lo_b;
    s1_bf  <= inv[W-1] ? lo_b : hi_b;
    s1_st  <= start;
    s1_dr  <= dir;
    s1_inv <= inv;
    s2_dn  <= sat_sum({s1_bn[W-1], s1_bn} - {s1_st[W-1], s1_st});
    s2_df  <= sat_sum({s1_bf[W-1], s1_bf} - {s1_st[W-1], s1_st});
    s2_st  <= s1_st;
    s2_dr  <= s1_dr;
    s2_inv <= s1_inv;
    s3_pn  <= s2_dn * s2_inv;
    s3_pf  <= s2_df * s2_inv;
    s3_st  <= s2_st;
    s3_dr  <= s2_dr;
    tn      <= sat_prod(s3_pn);
    tf      <= sat_prod(s3_pf);
    start_o <= s3_st;
    dir_o   <= s3_dr;
  end

  assign out_valid = v[3];
endmodule
`default_nettype wire

// ----- src/rbsi_merge.sv -----
// Merges the three slabs and applies the distance window (2 stages).
// Depends on rbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbsi_merge #(
  parameter int W = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic signed [W-1:0] xn, xf, yn, yf, zn, zf,
  input  wire logic signed [W-1:0] t_lower,
  input  wire logic signed [W-1:0] t_upper,
  output logic                     out_valid,
  output logic                     hit,
  output logic signed [W-1:0]      t
);
  import rbsi_pkg::*;

  logic [1:0] v;
  logic s1_miss;
  logic signed [W-1:0] s1_tmin, s1_tmax, s1_zn, s1_zf, s1_tl, s1_tu;
  logic miss2;
  logic signed [W-1:0] tmin2, tmax2, tsel;

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else v <= {v[0], in_valid};
  end

  // First merge: x against y.
  always_ff @(posedge clk) begin
    s1_miss <= (xn > yf) || (yn > xf);
    s1_tmin <= (yn > xn) ? yn : xn;
    s1_tmax <= (yf < xf) ? yf : xf;
    s1_zn   <= zn;
    s1_zf   <= zf;
    s1_tl   <= t_lower;
    s1_tu   <= t_upper;
  end

  // Second merge with z, then the window test.
  always_comb begin
    miss2 = s1_miss || (s1_tmin > s1_zf) || (s1_zn > s1_tmax);
    tmin2 = (s1_zn > s1_tmin) ? s1_zn : s1_tmin;
    tmax2 = (s1_zf < s1_tmax) ? s1_zf : s1_tmax;
    tsel  = (tmin2 < s1_tl) ? tmax2 : tmin2;
  end

  always_ff @(posedge clk) begin
    hit <= !miss2 && !(tsel < s1_tl) && !(tsel > s1_tu);
    t   <= tsel;
  end

  assign out_valid = v[1];
endmodule
`default_nettype wire

// ----- src/rbsi_face.sv -----
// Hit point, offset from the center and face choice (4 stages, output registered).
// Depends on rbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbsi_face #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                hit_in,
  input  wire logic signed [W-1:0] t_in,
  input  wire logic signed [W-1:0] st [3],
  input  wire logic signed [W-1:0] dr [3],
  input  wire logic signed [W-1:0] cen [3],
  output logic                     done,
  output logic                     hit,
  output logic signed [W-1:0]      t_hit,
  output logic [2:0]               face,
  output logic                     no_face
);
  import rbsi_pkg::*;

  function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] v);
    if (v[W] != v[W-1]) sat_sum = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else sat_sum = v[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sat_prod(input logic signed [2*W-1:0] p);
    logic signed [2*W-1:0] s;
    s = p >>> F;
    if (s[2*W-1:W-1] != {(W+1){1'b0}} && s[2*W-1:W-1] != {(W+1){1'b1}})
      sat_prod = s[2*W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    else sat_prod = s[W-1:0];
  endfunction

  logic [2:0] v;
  logic s1_hit, s2_hit, s3_hit;
  logic signed [W-1:0] s1_t, s2_t, s3_t;
  logic signed [2*W-1:0] s1_prod [3];
  logic signed [W-1:0] s1_st [3];
  logic signed [W-1:0] s2_p [3];
  logic signed [W-1:0] s3_off [3];
  logic signed [W-1:0] m [3];
  logic signed [W:0] best, cand;
  logic [2:0] face_sel;
  logic found;

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[1:0], in_valid};
      done <= v[2];
    end
  end

  // Products, hit point and offset per axis.
  always_ff @(posedge clk) begin
    s1_hit <= hit_in;
    s1_t   <= t_in;
    s2_hit <= s1_hit;
    s2_t   <= s1_t;
    s3_hit <= s2_hit;
    s3_t   <= s2_t;
    for (int i = 0; i < 3; i++) begin
      s1_prod[i] <= t_in * dr[i];
      s1_st[i]   <= st[i];
      s2_p[i]    <= sat_sum({s1_st[i][W-1], s1_st[i]} + {m[i][W-1], m[i]});
      s3_off[i]  <= sat_sum({s2_p[i][W-1], s2_p[i]} - {cen[i][W-1], cen[i]});
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) m[i] = sat_prod(s1_prod[i]);
  end

  // Largest offset magnitude over both signs of each component; the earlier face wins ties.
  always_comb begin
    best     = '0;
    face_sel = 3'd0;
    found    = 1'b0;
    cand     = '0;
    for (int i = 0; i < 3; i++) begin
      cand = {s3_off[i][W-1], s3_off[i]};
      if (cand > best) begin
        best = cand; face_sel = 3'(2 * i); found = 1'b1;
      end
      cand = -cand;
      if (cand > best) begin
        best = cand; face_sel = 3'(2 * i + 1); found = 1'b1;
      end
    end
  end

  // Result register; a miss reports all zeros.
  always_ff @(posedge clk) begin
    hit     <= s3_hit;
    t_hit   <= s3_hit ? s3_t : '0;
    face    <= (s3_hit && found) ? face_sel : 3'd0;
    no_face <= s3_hit && !found;
  end
endmodule
`default_nettype wire

// ----- tb/ray_box_slab_intersect_tb.sv -----
// Self-checking testbench for the ray/box slab intersection block.
// Depends on rbsi_pkg and ray_box_slab_intersect; a scoreboard class predicts each result.
`timescale 1ns / 1ps

module ray_box_slab_intersect_tb;
  import rbsi_pkg::*;

  localparam int W = 32;
  localparam int FB = 16;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int LATENCY = 10;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct {
    logic signed [W-1:0] st[3];
    logic signed [W-1:0] dr[3];
    logic signed [W-1:0] iv[3];
    logic signed [W-1:0] tl;
    logic signed [W-1:0] tu;
  } ray_req_t;

  typedef struct {
    logic hit;
    logic signed [W-1:0] t_hit;
    logic [2:0] face;
    logic no_face;
  } box_hit_t;

  function automatic longint clamp32(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  // Fixed-point product: floor of exact product >> FB, then saturated.
  function automatic longint qmul(longint a, longint b);
    logic signed [127:0] p;
    p = 128'(signed'(a)) * 128'(signed'(b));
    p = p >>> FB;
    if (p > 128'(VMAX)) return VMAX;
    if (p < -128'sd2147483648) return VMIN;
    return longint'(p);
  endfunction

  class hit_scoreboard;
    longint center[3];
    longint size[3];
    box_hit_t pending[$];
    int mismatches;

    function void reset_box();
      for (int i = 0; i < 3; i++) begin
        center[i] = 0;
        size[i] = 65536;
      end
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [W-1:0] data);
      case (idx)
        REG_CENTER_X: center[0] = longint'(signed'(data));
        REG_CENTER_Y: center[1] = longint'(signed'(data));
        REG_CENTER_Z: center[2] = longint'(signed'(data));
        REG_SIZE_X: size[0] = longint'({33'd0, data[W-2:0]});
        REG_SIZE_Y: size[1] = longint'({33'd0, data[W-2:0]});
        REG_SIZE_Z: size[2] = longint'({33'd0, data[W-2:0]});
        default: ;
      endcase
    endfunction

    function void slab_range(int ax, longint st, longint inv, output longint tn,
                             output longint tf);
      longint half, lo, hi, bn, bf;
      half = size[ax] >>> 1;
      lo = clamp32(center[ax] - half);
      hi = clamp32(center[ax] + half);
      bn = (inv < 0) ? hi : lo;
      bf = (inv < 0) ? lo : hi;
      tn = qmul(clamp32(bn - st), inv);
      tf = qmul(clamp32(bf - st), inv);
    endfunction

    // Note an accepted request and queue its expected result.
    function void note_request(ray_req_t r);
      box_hit_t e;
      longint tmin, tmax, n, f, t, best, off, p;
      e = '{hit: 1'b0, t_hit: '0, face: '0, no_face: 1'b0};
      slab_range(0, r.st[0], r.iv[0], tmin, tmax);
      for (int ax = 1; ax < 3; ax++) begin
        slab_range(ax, r.st[ax], r.iv[ax], n, f);
        if (tmin > f || n > tmax) begin
          pending.push_back(e);
          return;
        end
        if (n > tmin) tmin = n;
        if (f < tmax) tmax = f;
      end
      t = tmin;
      if (t < r.tl) t = tmax;
      if (t < r.tl || t > r.tu) begin
        pending.push_back(e);
        return;
      end
      best = 0;
      e.hit = 1'b1;
      e.t_hit = t[W-1:0];
      e.no_face = 1'b1;
      for (int i = 0; i < 3; i++) begin
        p = clamp32(r.st[i] + qmul(t, r.dr[i]));
        off = clamp32(p - center[i]);
        if (off > best) begin
          best = off; e.face = 3'(2 * i); e.no_face = 1'b0;
        end
        if (-off > best) begin
          best = -off; e.face = 3'(2 * i + 1); e.no_face = 1'b0;
        end
      end
      pending.push_back(e);
    endfunction

    // Compare a delivered result with the oldest expectation.
    function void check_result(box_hit_t a);
      box_hit_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hit=%0b t=%0d", a.hit, a.t_hit);
        return;
      end
      e = pending.pop_front();
      if (a.hit !== e.hit || a.t_hit !== e.t_hit || a.face !== e.face ||
          a.no_face !== e.no_face) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp hit=%0b t=%0d face=%0d nf=%0b, got hit=%0b t=%0d face=%0d nf=%0b",
                   e.hit, e.t_hit, e.face, e.no_face, a.hit, a.t_hit, a.face, a.no_face);
      end
    endfunction
  endclass

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done, hit, no_face;
  logic signed [W-1:0] start_x, start_y, start_z, dir_x, dir_y, dir_z;
  logic signed [W-1:0] inv_dir_x, inv_dir_y, inv_dir_z, t_lower, t_upper, t_hit;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [W-1:0] cfg_data;
  logic [2:0] face;

  hit_scoreboard sb;
  int idle_cycles;

  ray_box_slab_intersect u_top (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Score every result strobe and count cycles with no handshake.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result('{hit: hit, t_hit: t_hit, face: face, no_face: no_face});
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ray_box_slab_intersect verification failed");
      $finish;
    end
  end

  task automatic idle(int n);
    repeat (n) @(negedge clk);
  endtask

  // Start stays high when the next request follows at once.
  task automatic send_ray(ray_req_t r);
    int gap;
    start_x <= r.st[0]; start_y <= r.st[1]; start_z <= r.st[2];
    dir_x <= r.dr[0]; dir_y <= r.dr[1]; dir_z <= r.dr[2];
    inv_dir_x <= r.iv[0]; inv_dir_y <= r.iv[1]; inv_dir_z <= r.iv[2];
    t_lower <= r.tl; t_upper <= r.tu;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    @(negedge clk);
    gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      idle(gap);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    idle(LATENCY + 2);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [W-1:0] data);
    cfg_index <= idx; cfg_data <= data; cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly modest values so rays meet the box; sometimes full range.
  function automatic logic [W-1:0] pick(int mag);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return 32'd0;
      default: return W'($signed($urandom_range(0, 2 * mag)) - mag);
    endcase
  endfunction

  function automatic ray_req_t random_ray();
    ray_req_t r;
    for (int i = 0; i < 3; i++) begin
      r.st[i] = pick(6 << 16);
      r.dr[i] = pick(2 << 16);
      r.iv[i] = pick(4 << 16);
    end
    r.tl = ($urandom_range(0, 3) == 0) ? pick(2 << 16) : 32'sd0;
    r.tu = ($urandom_range(0, 3) == 0) ? pick(20 << 16) : 32'sh7fffffff;
    return r;
  endfunction

  function automatic ray_req_t axis_ray(int ax, bit neg, int tl, int tu);
    ray_req_t r;
    for (int i = 0; i < 3; i++) begin
      r.st[i] = 0; r.dr[i] = 0; r.iv[i] = 0;
    end
    r.st[ax] = neg ? (3 << 16) : -(3 << 16);
    r.dr[ax] = neg ? -(1 << 16) : (1 << 16);
    r.iv[ax] = r.dr[ax];
    r.tl = tl; r.tu = tu;
    return r;
  endfunction

  task automatic random_box(bit extreme);
    for (int i = 0; i < 3; i++) begin
      write_reg(CFG_INDEX_WIDTH'(REG_CENTER_X + i),
                extreme ? $urandom() : W'($signed($urandom_range(0, 4 << 16)) - (2 << 16)));
      write_reg(CFG_INDEX_WIDTH'(REG_SIZE_X + i),
                extreme ? $urandom() : $urandom_range(1, 8 << 16));
    end
  endtask

  initial begin
    ray_req_t r;
    sb = new();
    sb.reset_box();
    idle_cycles = 0;
    rst = 1'b1; start = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    {start_x, start_y, start_z, dir_x, dir_y, dir_z} = '0;
    {inv_dir_x, inv_dir_y, inv_dir_z, t_lower, t_upper} = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: each face, window clipping, exit use, misses, extremes.
    for (int ax = 0; ax < 3; ax++) begin
      send_ray(axis_ray(ax, 0, 0, 32'sh7fffffff));
      send_ray(axis_ray(ax, 1, 0, 32'sh7fffffff));
    end
    send_ray(axis_ray(0, 0, 3 << 16, 32'sh7fffffff));
    send_ray(axis_ray(0, 0, 0, 1 << 16));
    send_ray(axis_ray(1, 0, 5 << 16, 32'sh7fffffff));
    r = axis_ray(0, 0, 0, 32'sh7fffffff); r.st[0] = 0; send_ray(r);
    r.dr[0] = 0; send_ray(r);
    r = axis_ray(2, 0, 32'sh80000000, 32'sh7fffffff); r.iv[2] = 0; send_ray(r);
    r = axis_ray(0, 0, 0, 32'sh7fffffff); r.st[1] = 5 << 16; send_ray(r);
    for (int i = 0; i < 3; i++) begin
      r.st[i] = 32'sh7fffffff; r.dr[i] = 32'sh80000000; r.iv[i] = 32'sh80000000;
    end
    r.tl = 32'sh80000000; r.tu = 32'sh7fffffff;
    send_ray(r);
    for (int i = 0; i < 3; i++) begin
      r.st[i] = 32'sh80000000; r.dr[i] = 32'sh7fffffff; r.iv[i] = 32'sh7fffffff;
    end
    send_ray(r);
    r = axis_ray(0, 0, 32'sh7fffffff, 32'sh80000000); send_ray(r);

    // Extreme box settings, including the unused index.
    drain();
    write_reg(REG_CENTER_X, 32'h7fffffff); write_reg(REG_CENTER_Y, 32'h80000000);
    write_reg(REG_CENTER_Z, 32'h0);
    write_reg(REG_SIZE_X, 32'hffffffff); write_reg(REG_SIZE_Y, 32'h0);
    write_reg(REG_SIZE_Z, 32'h7fffffff);
    write_reg(CFG_INDEX_WIDTH'(6), 32'h12345678);
    for (int k = 0; k < 20; k++) send_ray(random_ray());

    // Random phases, each on a fresh box.
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      random_box(ph == 4 || ph == 7);
      for (int k = 0; k < 120; k++) begin
        send_ray(random_ray());
        if (k == 60 && ph == 2) drain();
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("ray_box_slab_intersect verification clean");
    end else begin
      $display("ray_box_slab_intersect verification failed");
    end
    $finish;
  end
endmodule
